[src/xed_pkg.sv]
// Package for the XML entity decoder: payload types, job format, character constants.
`default_nettype none
package xed_pkg;

    // Character codes
    localparam logic [7:0] C_AMP  = 8'h26;  // '&'
    localparam logic [7:0] C_SEMI = 8'h3b;  // ';'
    localparam logic [7:0] C_LT   = 8'h3c;  // '<'
    localparam logic [7:0] C_GT   = 8'h3e;  // '>'

    // Longest entity and pending buffer depth
    localparam int CAND_LEN = 5;
    localparam int PEND_LEN = 4;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Candidate bytes, byte 0 first
    typedef logic [CAND_LEN-1:0][7:0] t_cand;

    // Entity patterns, unused tail bytes zero
    localparam t_cand P_AMP = {C_SEMI, 8'h70, 8'h6d, 8'h61, C_AMP};
    localparam t_cand P_LT  = {8'h00, C_SEMI, 8'h74, 8'h6c, C_AMP};
    localparam t_cand P_GT  = {8'h00, C_SEMI, 8'h74, 8'h67, C_AMP};

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PREFIX,
        KIND_DONE
    } t_kind;

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_last;
    } t_out;

    // All results caused by one input item
    typedef struct packed {
        t_cand      job_bytes;
        logic [2:0] job_cnt;    // 1..5
        logic       job_last;
    } t_job;

endpackage
`default_nettype wire

[src/xml_entity_decoder.sv]
// Top level of the streaming XML entity decoder.
// Accepts one byte per cycle if the queue is not full; each result is queued, then registered.
// Each byte yields up to five results, one per cycle as taken; a four-job queue holds bursts.
// One byte per cycle is sustained if output never stalls and bytes yield at most one result.
// Synchronous active-low reset empties the queue, drops any open prefix and sets lt/gt decoding.
`default_nettype none
module xml_entity_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire xed_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output xed_pkg::t_out      o_out
);

    logic          r_decode_lt_gt;
    logic          q_full, q_valid, push, pop;
    xed_pkg::t_job job_in, job_head;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_lt_gt <= 1'b1;
        end else if (i_cfg_we) begin
            r_decode_lt_gt <= i_cfg_wdata;
        end
    end

    xed_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_decode_lt_gt (r_decode_lt_gt),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (job_in)
    );

    xed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (job_head),
        .i_pop   (pop)
    );

    xed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

[src/xed_front.sv]
// Front end: accepts bytes, tracks the open entity prefix and builds a job for each byte that yields results.
`default_nettype none
module xed_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_decode_lt_gt,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire xed_pkg::t_in  i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output xed_pkg::t_job      o_job
);

    // Compare the first n candidate bytes against a pattern of length plen.
    // Letters fold to lower case; '&' and ';' compare exactly.
    function automatic xed_pkg::t_kind match_pat(
        input xed_pkg::t_cand c,
        input logic [2:0]     n,
        input xed_pkg::t_cand pat,
        input logic [2:0]     plen
    );
        logic       ok;
        logic [7:0] ch;
        ok = (n != 3'd0) && (n <= plen);
        for (int k = 0; k < xed_pkg::CAND_LEN; k++) begin
            ch = c[k];
            if (k != 0 && 3'(k + 1) < plen) begin
                ch = ch | 8'h20;
            end
            if (3'(k) < n && ch != pat[k]) begin
                ok = 1'b0;
            end
        end
        if (!ok) begin
            match_pat = xed_pkg::KIND_NONE;
        end else if (n == plen) begin
            match_pat = xed_pkg::KIND_DONE;
        end else begin
            match_pat = xed_pkg::KIND_PREFIX;
        end
    endfunction

    logic [xed_pkg::PEND_LEN-1:0][7:0] r_pend, n_pend;
    logic [2:0]                        r_cnt, n_cnt;

    xed_pkg::t_cand cand;
    logic [2:0]     n1;
    xed_pkg::t_kind k_amp, k_lt, k_gt;
    logic           is_done, is_prefix, accept;
    logic [7:0]     dec;
    logic [2:0]     m;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign n1         = r_cnt + 3'd1;

    // Candidate: held bytes followed by the new byte
    always_comb begin
        for (int k = 0; k < xed_pkg::PEND_LEN; k++) begin
            if (3'(k) < r_cnt) begin
                cand[k] = r_pend[k];
            end else if (3'(k) == r_cnt) begin
                cand[k] = i_in.in_byte;
            end else begin
                cand[k] = 8'h00;
            end
        end
        cand[xed_pkg::CAND_LEN-1] = (r_cnt == 3'(xed_pkg::PEND_LEN)) ? i_in.in_byte : 8'h00;
    end

    // Classify against the enabled entities
    always_comb begin
        k_amp = match_pat(cand, n1, xed_pkg::P_AMP, 3'd5);
        k_lt  = i_decode_lt_gt ? match_pat(cand, n1, xed_pkg::P_LT, 3'd4) : xed_pkg::KIND_NONE;
        k_gt  = i_decode_lt_gt ? match_pat(cand, n1, xed_pkg::P_GT, 3'd4) : xed_pkg::KIND_NONE;
        is_done = (k_amp == xed_pkg::KIND_DONE) || (k_lt == xed_pkg::KIND_DONE)
               || (k_gt == xed_pkg::KIND_DONE);
        is_prefix = !is_done && (r_cnt < 3'(xed_pkg::PEND_LEN))
                 && ((k_amp == xed_pkg::KIND_PREFIX) || (k_lt == xed_pkg::KIND_PREFIX)
                  || (k_gt == xed_pkg::KIND_PREFIX));
        if (k_amp == xed_pkg::KIND_DONE) begin
            dec = xed_pkg::C_AMP;
        end else if (k_lt == xed_pkg::KIND_DONE) begin
            dec = xed_pkg::C_LT;
        end else begin
            dec = xed_pkg::C_GT;
        end
    end

    // Result count, job and next prefix state
    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        o_job.job_bytes = cand;
        o_job.job_last  = i_in.in_last;
        if (is_done) begin
            m = 3'd1;
            o_job.job_bytes[0] = dec;
            n_cnt = 3'd0;
        end else if (is_prefix) begin
            m = i_in.in_last ? n1 : 3'd0;
            n_pend[r_cnt[1:0]] = i_in.in_byte;
            n_cnt = i_in.in_last ? 3'd0 : n1;
        end else if (i_in.in_byte == xed_pkg::C_AMP && !i_in.in_last) begin
            // broken prefix; the new '&' opens another one
            m = r_cnt;
            n_pend[0] = xed_pkg::C_AMP;
            n_cnt = 3'd1;
        end else begin
            m = n1;
            n_cnt = 3'd0;
        end
        o_job.job_cnt = m;
        o_push = accept && (m != 3'd0);
    end

    // Held bytes need no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[src/xed_queue.sv]
// Short job queue between the front end and the output serializer.
`default_nettype none
module xed_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire xed_pkg::t_job  i_job,
    output logic                o_full,
    output logic                o_valid,
    output xed_pkg::t_job       o_job,
    input  wire logic           i_pop
);

    xed_pkg::t_job r_mem [xed_pkg::Q_DEPTH];
    logic [xed_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [xed_pkg::Q_AW:0]   r_fill;

    assign o_full  = (r_fill == (xed_pkg::Q_AW + 1)'(xed_pkg::Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/xed_back.sv]
// Back end: serializes each job into result transfers through an output register.
`default_nettype none
module xed_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire xed_pkg::t_job  i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output xed_pkg::t_out       o_out
);

    logic [2:0]    r_idx;
    logic          r_ov;
    xed_pkg::t_out r_out;
    logic          adv, fin;

    // Load a new result when the output register is free or draining
    assign adv   = i_job_valid && (!r_ov || i_out_ready);
    assign fin   = (r_idx == i_job.job_cnt - 3'd1);
    assign o_pop = adv && fin;

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // Result payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_byte    <= i_job.job_bytes[r_idx];
            r_out.run_last    <= fin;
            r_out.string_last <= fin && i_job.job_last;
        end
    end

    // Byte index within the job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_ov  <= 1'b0;
        end else begin
            if (adv) begin
                r_idx <= fin ? 3'd0 : r_idx + 3'd1;
                r_ov  <= 1'b1;
            end else if (i_out_ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
